@@ rtl/dpt_pkg.sv @@
// Shared constants and types for the demand paging translator.
// Used by the controller, the datapath and the top level; depends on nothing.
package dpt_pkg;

    localparam int ADDR_W = 16;
    localparam int OFFSET_SPAN = 256;
    localparam int OFFSET_W = $clog2(OFFSET_SPAN);
    localparam int PAGE_NUM_W = ADDR_W - OFFSET_W;
    localparam int VICTIM_W = 8;

    localparam int DEFAULT_PAGE_COUNT = 256;
    localparam int DEFAULT_FRAME_COUNT = 256;

    typedef struct packed {
        logic load_addr;
        logic lookup;
        logic emit;
    } dpt_cmd_t;

    typedef struct packed {
        logic out_free;
    } dpt_stat_t;

endpackage

@@ rtl/demand_paging_translator.sv @@
// Top level of the demand paging translator: one logical address word in,
// one translated word out. Instantiates dpt_ctrl and dpt_dpath; uses dpt_pkg.
//
// Each accepted address is split into a page number and an offset; a mapped page
// gives frame * OFFSET_SPAN + offset, an unmapped page faults and takes the next
// unused frame, or frame 0 once every frame has been handed out, in which case
// the page that held frame 0 is unmapped and reported as the victim. An accepted
// word reaches the output register through table lookup and update on the single
// page table port, then output load, and the load waits while the previous
// result is still held. The next word is accepted in the cycle after the result
// is loaded, even while that result is still waiting on the output side, so no
// word is taken before the previous one is loaded. Frames are never released, so the
// free search is a running allocation count and no clearing pass follows reset.
module demand_paging_translator
    import dpt_pkg::*;
#(
    parameter int PAGE_COUNT = DEFAULT_PAGE_COUNT,
    parameter int FRAME_COUNT = DEFAULT_FRAME_COUNT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ADDR_W-1:0]   logical_addr,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [ADDR_W-1:0]   physical_addr,
    output logic                page_fault,
    output logic                victim_evicted,
    output logic [VICTIM_W-1:0] victim_page
);

    dpt_cmd_t  cmd;
    dpt_stat_t stat;

    dpt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dpt_dpath #(
        .PAGE_COUNT  (PAGE_COUNT),
        .FRAME_COUNT (FRAME_COUNT)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .logical_addr   (logical_addr),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .physical_addr  (physical_addr),
        .page_fault     (page_fault),
        .victim_evicted (victim_evicted),
        .victim_page    (victim_page)
    );

endmodule

@@ rtl/dpt_ctrl.sv @@
// Sequencing controller for the demand paging translator.
// Depends on dpt_pkg for the command and status types.
module dpt_ctrl
    import dpt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  dpt_stat_t stat,
    output dpt_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOOK = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_addr = 1'b1;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                cmd.lookup = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/dpt_dpath.sv @@
// Datapath of the demand paging translator: page table, valid map,
// frame allocation counter, frame 0 owner and output register. Uses dpt_pkg.
module dpt_dpath
    import dpt_pkg::*;
#(
    parameter int PAGE_COUNT = DEFAULT_PAGE_COUNT,
    parameter int FRAME_COUNT = DEFAULT_FRAME_COUNT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  dpt_cmd_t            cmd,
    output dpt_stat_t           stat,
    input  logic [ADDR_W-1:0]   logical_addr,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [ADDR_W-1:0]   physical_addr,
    output logic                page_fault,
    output logic                victim_evicted,
    output logic [VICTIM_W-1:0] victim_page
);

    localparam int PAGE_SPAN = 2 ** PAGE_NUM_W;
    localparam int PAGE_SLOTS = (PAGE_COUNT < PAGE_SPAN) ? PAGE_COUNT : PAGE_SPAN;
    localparam int PW = $clog2(PAGE_SLOTS);
    localparam int FW = $clog2(FRAME_COUNT);
    localparam int FCW = $clog2(FRAME_COUNT + 1);

    logic [PW-1:0]         page_lut [PAGE_SPAN];
    logic [ADDR_W-1:0]     addr_reg;
    logic [PW-1:0]         page_idx;
    logic [OFFSET_W-1:0]   offset;
    logic [PAGE_SLOTS-1:0] page_valid_reg;
    logic [PAGE_SLOTS-1:0] page_valid_next;
    logic [FW-1:0]         page_frame_mem [PAGE_SLOTS];
    logic [FW-1:0]         rd_frame_reg;
    logic [FCW-1:0]        next_free_reg;
    logic [PW-1:0]         owner0_reg;
    logic                  frames_full;
    logic                  miss;
    logic [FW-1:0]         alloc_frame;
    logic                  fault_reg;
    logic                  evict_reg;
    logic [PW-1:0]         victim_reg;
    logic [FW-1:0]         fault_frame_reg;
    logic [FW-1:0]         result_frame;
    logic                  out_valid_reg;
    logic [ADDR_W-1:0]     phys_reg;
    logic                  fault_out_reg;
    logic                  evict_out_reg;
    logic [VICTIM_W-1:0]   victim_out_reg;

    for (genvar i = 0; i < PAGE_SPAN; i++)
    begin : g_page_lut
        assign page_lut[i] = PW'(i % PAGE_COUNT);
    end

    assign page_idx = page_lut[addr_reg[ADDR_W-1:OFFSET_W]];
    assign offset = addr_reg[OFFSET_W-1:0];
    assign frames_full = (next_free_reg == FCW'(FRAME_COUNT));
    assign miss = !page_valid_reg[page_idx];
    assign alloc_frame = frames_full ? '0 : next_free_reg[FW-1:0];
    assign result_frame = fault_reg ? fault_frame_reg : rd_frame_reg;

    always_comb
    begin
        page_valid_next = page_valid_reg;
        if (cmd.lookup && miss)
        begin
            if (frames_full)
            begin
                page_valid_next[owner0_reg] = 1'b0;
            end
            page_valid_next[page_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_valid_reg <= '0;
            next_free_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            page_valid_reg <= page_valid_next;
            if (cmd.lookup && miss && !frames_full)
            begin
                next_free_reg <= next_free_reg + FCW'(1);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            if (miss)
            begin
                page_frame_mem[page_idx] <= alloc_frame;
            end
            rd_frame_reg <= page_frame_mem[page_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_addr)
        begin
            addr_reg <= logical_addr;
        end
        if (cmd.lookup)
        begin
            fault_reg <= miss;
            evict_reg <= miss && frames_full;
            victim_reg <= owner0_reg;
            fault_frame_reg <= alloc_frame;
            if (miss && alloc_frame == '0)
            begin
                owner0_reg <= page_idx;
            end
        end
        if (cmd.emit)
        begin
            phys_reg <= ADDR_W'({result_frame, offset});
            fault_out_reg <= fault_reg;
            evict_out_reg <= evict_reg;
            victim_out_reg <= evict_reg ? VICTIM_W'(victim_reg) : '0;
        end
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign physical_addr = phys_reg;
    assign page_fault = fault_out_reg;
    assign victim_evicted = evict_out_reg;
    assign victim_page = victim_out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        next_free_reg <= FCW'(FRAME_COUNT))
        else $error("frame allocation count ran past the frame count");

    a_miss_maps: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.lookup && miss |=> page_valid_reg[page_idx])
        else $error("faulting page is not valid after its fault");

    a_evict_is_fault: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && evict_out_reg |-> fault_out_reg)
        else $error("eviction reported without a page fault");

    a_evict_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.lookup && miss && frames_full |=> !page_valid_reg[$past(owner0_reg)]
            || $past(owner0_reg) == $past(page_idx))
        else $error("victim page still valid after eviction");

endmodule
